### rtl/core/ssnw_pkg.sv
package ssnw_pkg;

  localparam int unsigned DigitCountDefault = 8;
  localparam int unsigned ValueW            = 32;
  localparam int unsigned BcdDigits         = 10;
  localparam int unsigned BcdW              = 4 * BcdDigits;
  localparam int unsigned BitsPerStep       = 4;
  localparam int unsigned ConvSteps         = ValueW / BitsPerStep;
  localparam int unsigned ConvCntW          = $clog2(ConvSteps);
  localparam int unsigned AddrW             = 4;
  localparam int unsigned DataW             = 8;
  localparam int unsigned IntensityW        = 4;
  localparam int unsigned ScanW             = 3;
  localparam int unsigned CfgIdxW           = 1;
  localparam int unsigned CfgDataW          = 4;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned QueuePtrW         = $clog2(QueueDepth);

  localparam logic [CfgIdxW-1:0] CfgIntensity = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgScan      = 1'd1;

  localparam logic [AddrW-1:0] AddrDecode    = 4'h9;
  localparam logic [AddrW-1:0] AddrIntensity = 4'hA;
  localparam logic [AddrW-1:0] AddrScan      = 4'hB;
  localparam logic [AddrW-1:0] AddrShutdown  = 4'hC;
  localparam logic [AddrW-1:0] AddrTest      = 4'hF;

  localparam logic [DataW-1:0] PointBit = 8'h80;

  localparam logic [2:0] InitTest      = 3'd0;
  localparam logic [2:0] InitScan      = 3'd1;
  localparam logic [2:0] InitDecode    = 3'd2;
  localparam logic [2:0] InitIntensity = 3'd3;
  localparam logic [2:0] InitShutdown  = 3'd4;

  function automatic logic [DataW-1:0] seg_code(input logic [3:0] digit);
    logic [DataW-1:0] code;
    case (digit)
      4'd0:    code = 8'h7E;
      4'd1:    code = 8'h30;
      4'd2:    code = 8'h6D;
      4'd3:    code = 8'h79;
      4'd4:    code = 8'h33;
      4'd5:    code = 8'h5B;
      4'd6:    code = 8'h5F;
      4'd7:    code = 8'h70;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h7B;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // one shift-and-add-3 step, next binary bit enters at the bottom
  function automatic logic [BcdW-1:0] dd_step(input logic [BcdW-1:0] bcd, input logic b);
    logic [BcdW-1:0] adj;
    adj = bcd;
    for (int i = 0; i < BcdDigits; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BcdW-2:0], b};
  endfunction

endpackage

### rtl/core/ssnw_fifo.sv
module ssnw_fifo
  import ssnw_pkg::*;
#(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0]       mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]     count_q, count_d;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/ssnw_front.sv
module ssnw_front
  import ssnw_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DigitCountDefault,
  parameter int unsigned EntryW      = 2 + 5 * DIGIT_COUNT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic [ValueW-1:0] value_i,
  input  logic              with_point_i,
  input  logic              send_init_i,
  output logic              q_push_o,
  output logic [EntryW-1:0] q_data_o,
  input  logic              q_full_i
);

  logic                    busy_q, done_q;
  logic [ConvCntW-1:0]     cnt_q;
  logic [ValueW-1:0]       bin_q;
  logic [BcdW-1:0]         bcd_q, bcd_d;
  logic                    point_q, init_q;
  logic [BcdDigits-1:0]    nz;
  logic [DIGIT_COUNT-1:0]  show;
  logic                    accept, handoff;

  assign handoff  = done_q && !q_full_i;
  assign full_o   = busy_q || (done_q && q_full_i);
  assign accept   = push_i && !full_o;
  assign q_push_o = done_q;

  always_comb begin
    bcd_d = bcd_q;
    for (int s = 0; s < BitsPerStep; s++) begin
      bcd_d = dd_step(bcd_d, bin_q[ValueW-1-s]);
    end
  end

  always_comb begin
    for (int j = 0; j < BcdDigits; j++) begin
      nz[j] = |bcd_q[4*j +: 4];
    end
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      show[i] = (i == 0) || ((nz >> i) != '0);
    end
  end

  assign q_data_o = {init_q, point_q, show, bcd_q[4*DIGIT_COUNT-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == ConvCntW'(ConvSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (handoff) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      bin_q   <= value_i;
      bcd_q   <= '0;
      point_q <= with_point_i;
      init_q  <= send_init_i;
    end else if (busy_q) begin
      bin_q <= {bin_q[ValueW-BitsPerStep-1:0], BitsPerStep'(0)};
      bcd_q <= bcd_d;
    end
  end

endmodule

### rtl/core/ssnw_back.sv
module ssnw_back
  import ssnw_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DigitCountDefault,
  parameter int unsigned EntryW      = 2 + 5 * DIGIT_COUNT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [EntryW-1:0]     q_data_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic [IntensityW-1:0] intensity_i,
  input  logic [ScanW-1:0]      scan_i,
  output logic                  empty_o,
  input  logic                  pop_i,
  output logic [AddrW-1:0]      reg_addr_o,
  output logic [DataW-1:0]      reg_data_o,
  output logic                  last_write_o
);

  localparam int unsigned LeftW = $clog2(DIGIT_COUNT + 1);
  localparam int unsigned DigW  = 4 * DIGIT_COUNT;

  typedef enum logic [1:0] {ST_IDLE, ST_INIT, ST_DIGIT} state_e;

  state_e               state_q, state_d;
  logic [2:0]           iidx_q, cur_iidx;
  logic [LeftW-1:0]     left_q, cur_left;
  logic [AddrW-1:0]     addr_q, cur_addr;
  logic [DigW-1:0]      digits_q, cur_digits;
  logic [DIGIT_COUNT-1:0] show_q, cur_show;
  logic                 point_q, cur_point, cur_init;
  logic                 out_valid_q;
  logic [AddrW-1:0]     addr_w;
  logic [DataW-1:0]     data_w;
  logic                 last_w, adv, have_work, fire;

  assign adv       = !out_valid_q || pop_i;
  assign have_work = (state_q != ST_IDLE) || !q_empty_i;
  assign fire      = adv && have_work;
  assign q_pop_o   = fire && (state_q == ST_IDLE);
  assign empty_o   = !out_valid_q;

  always_comb begin
    if (state_q == ST_IDLE) begin
      cur_init   = q_data_i[EntryW-1];
      cur_point  = q_data_i[EntryW-2];
      cur_show   = q_data_i[DigW +: DIGIT_COUNT];
      cur_digits = q_data_i[DigW-1:0];
      cur_iidx   = InitTest;
      cur_addr   = AddrW'(DIGIT_COUNT);
      cur_left   = LeftW'(DIGIT_COUNT);
    end else begin
      cur_init   = (state_q == ST_INIT);
      cur_point  = point_q;
      cur_show   = show_q;
      cur_digits = digits_q;
      cur_iidx   = iidx_q;
      cur_addr   = addr_q;
      cur_left   = left_q;
    end
  end

  always_comb begin
    addr_w  = cur_addr;
    data_w  = '0;
    last_w  = 1'b0;
    state_d = state_q;
    if (cur_init) begin
      case (cur_iidx)
        InitTest: begin
          addr_w = AddrTest;
        end
        InitScan: begin
          addr_w = AddrScan;
          data_w = DataW'(scan_i);
        end
        InitDecode: begin
          addr_w = AddrDecode;
        end
        InitIntensity: begin
          addr_w = AddrIntensity;
          data_w = DataW'(intensity_i);
        end
        default: begin
          addr_w = AddrShutdown;
          data_w = 8'h01;
        end
      endcase
      state_d = (cur_iidx == InitShutdown) ? ST_DIGIT : ST_INIT;
    end else begin
      if (cur_show[0]) begin
        data_w = seg_code(cur_digits[3:0]) | (cur_point ? PointBit : '0);
      end
      last_w  = (cur_left == LeftW'(1));
      state_d = last_w ? ST_IDLE : ST_DIGIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      iidx_q       <= InitTest;
      left_q       <= '0;
      reg_addr_o   <= '0;
      reg_data_o   <= '0;
      last_write_o <= 1'b0;
      point_q      <= 1'b0;
      addr_q       <= '0;
      digits_q     <= '0;
      show_q       <= '0;
    end else begin
      if (fire) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
        reg_addr_o  <= addr_w;
        reg_data_o  <= data_w;
        last_write_o <= last_w;
        point_q     <= cur_point;
        if (cur_init) begin
          iidx_q   <= cur_iidx + 1'b1;
          left_q   <= cur_left;
          addr_q   <= cur_addr;
          digits_q <= cur_digits;
          show_q   <= cur_show;
        end else begin
          iidx_q   <= cur_iidx;
          left_q   <= cur_left - 1'b1;
          addr_q   <= cur_addr - 1'b1;
          digits_q <= cur_digits >> 4;
          show_q   <= cur_show >> 1;
        end
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/seven_segment_number_writer.sv
// Number-to-display writer.
// Input queue: drive value_i, with_point_i and send_init_i with push; the request is
// taken at a clock edge where push is high and full is low.
// Result queue: while empty is low, reg_addr_o, reg_data_o and last_write_o show the
// oldest register write; pop at an edge where empty is low takes it.
// Each request gives DIGIT_COUNT digit writes, preceded by five setup writes when
// send_init_i is set; last_write_o marks the final write of a request.
// Config: cfg_we_i writes cfg_data_i to intensity (index 0) or scan limit (index 1)
// at the clock edge; write only while the block is idle.
// Conversion: the front converts the value to decimal four bits a cycle; the result then
// passes through the queue and the back's output register before the first write appears.
// Throughput: the back issues one write per cycle while results are popped, so a request
// fills the result queue with DIGIT_COUNT writes, plus five setup writes with send_init_i;
// the front converts one request at a time; a two-entry queue absorbs the difference.
// A stalled result holds on the ports; the back and then the front stall behind it
// while full keeps further requests out.
// Reset clears all control state and sets intensity to 15 and scan limit to 7.
module seven_segment_number_writer
  import ssnw_pkg::*;
#(
  parameter int unsigned DIGIT_COUNT = DigitCountDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [ValueW-1:0]   value_i,
  input  logic                with_point_i,
  input  logic                send_init_i,
  output logic                empty,
  input  logic                pop,
  output logic [AddrW-1:0]    reg_addr_o,
  output logic [DataW-1:0]    reg_data_o,
  output logic                last_write_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned EntryW = 2 + 5 * DIGIT_COUNT;

  logic [IntensityW-1:0] intensity_q;
  logic [ScanW-1:0]      scan_q;
  logic                  q_push, q_full, q_pop, q_empty;
  logic [EntryW-1:0]     q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= 4'd15;
      scan_q      <= 3'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgIntensity: intensity_q <= cfg_data_i[IntensityW-1:0];
        CfgScan:      scan_q      <= cfg_data_i[ScanW-1:0];
        default: begin
        end
      endcase
    end
  end

  ssnw_front #(
    .DIGIT_COUNT(DIGIT_COUNT),
    .EntryW     (EntryW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .value_i     (value_i),
    .with_point_i(with_point_i),
    .send_init_i (send_init_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata),
    .q_full_i    (q_full)
  );

  ssnw_fifo #(
    .WIDTH(EntryW)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  ssnw_back #(
    .DIGIT_COUNT(DIGIT_COUNT),
    .EntryW     (EntryW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (q_rdata),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .intensity_i (intensity_q),
    .scan_i      (scan_q),
    .empty_o     (empty),
    .pop_i       (pop),
    .reg_addr_o  (reg_addr_o),
    .reg_data_o  (reg_data_o),
    .last_write_o(last_write_o)
  );

endmodule

### rtl/core/ssnw_checker.sv
module ssnw_checker
  import ssnw_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             empty,
  input logic             pop,
  input logic [AddrW-1:0] reg_addr_o,
  input logic [DataW-1:0] reg_data_o,
  input logic             last_write_o
);

  a_last_is_digit_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_write_o) |-> (reg_addr_o == 4'd1))
    else $error("final write of a request not to digit register 1");

  a_ctrl_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && reg_addr_o >= AddrDecode) |-> !last_write_o)
    else $error("setup write marked as final");

  a_blank_no_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (reg_data_o != PointBit))
    else $error("point bit on a blank position");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(reg_addr_o) && $stable(reg_data_o)
                          && $stable(last_write_o)))
    else $error("stalled result changed");

endmodule

bind seven_segment_number_writer ssnw_checker u_ssnw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty       (empty),
  .pop         (pop),
  .reg_addr_o  (reg_addr_o),
  .reg_data_o  (reg_data_o),
  .last_write_o(last_write_o)
);
